// File: design/clipped_shape_fill_rasterizer_macros.svh
// ============================================================================
// Assertion macros for the clipped shape fill rasterizer
// Short forms for clocked concurrent assertions, with and without reset gating.
// ============================================================================
`ifndef CLIPPED_SHAPE_FILL_RASTERIZER_MACROS_SVH
`define CLIPPED_SHAPE_FILL_RASTERIZER_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CSFR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also watches the reset cycles.
`define CSFR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/csfr_pkg.sv
// ============================================================================
// Clipped shape fill rasterizer package
// Shared types, command codes and register indexes.
// ============================================================================
`default_nettype none

package csfr_pkg;

  // Internal coordinate width; holds every intermediate span bound.
  localparam int CW = 14;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_W-1:0] CANVAS_SIZE_RESET = 7'd64;

  // Command codes as seen on the input channel.
  localparam logic [2:0] ACT_CLEAR   = 3'd0;
  localparam logic [2:0] ACT_POINT   = 3'd1;
  localparam logic [2:0] ACT_RECT    = 3'd2;
  localparam logic [2:0] ACT_DIAMOND = 3'd3;
  localparam logic [2:0] ACT_READ    = 3'd4;

  // Output row width.
  localparam int ROW_W = 64;

  typedef logic signed [CW-1:0] coord_t;

  // Row operation carried out by the sweep.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_FILL    = 3'd2,
    OP_DIAMOND = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  // Command context held for the whole sweep.
  typedef struct packed {
    op_t        op;
    coord_t     x_lo;    // left column, or diamond center column
    coord_t     x_hi;    // right column
    coord_t     y_lo;    // bottom row, or diamond center row
    coord_t     y_hi;    // top row
    logic [9:0] radius;
  } span_ctx_t;

  // Per-row control travelling down the row pipeline.
  typedef struct packed {
    logic valid;
    logic wr;
    logic cap;
    logic clr;
  } row_ctl_t;

endpackage

`default_nettype wire

// File: design/csfr_intf.sv
// ============================================================================
// Clipped shape fill rasterizer channels
// Command, row result and configuration write channels with valid/ready.
// ============================================================================
`default_nettype none

interface csfr_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic signed [10:0] pos_x;
  logic signed [10:0] pos_y;
  logic [9:0]        rect_width;
  logic [9:0]        rect_height;
  logic [9:0]        diamond_radius;

  modport source (output valid, action, pos_x, pos_y, rect_width, rect_height,
                  diamond_radius, input ready);
  modport sink (input valid, action, pos_x, pos_y, rect_width, rect_height,
                diamond_radius, output ready);
endinterface

interface csfr_row_if;
  logic        valid;
  logic        ready;
  logic [63:0] row_bits;

  modport source (output valid, row_bits, input ready);
  modport sink (input valid, row_bits, output ready);
endinterface

interface csfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/csfr_canvas.sv
// ============================================================================
// Canvas row store
// One row per entry, one read and one write port, registered read data.
// ============================================================================
`default_nettype none

module csfr_canvas
  import csfr_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64,
  localparam int RW = $clog2(MAX_ROWS)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [RW-1:0]          rd_addr,
  output      logic [MAX_COLUMNS-1:0] rd_data,
  input  wire logic                   wr_en,
  input  wire logic [RW-1:0]          wr_addr,
  input  wire logic [MAX_COLUMNS-1:0] wr_data
);

  logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]    row_valid;
  logic [MAX_COLUMNS-1:0] mem_q;
  logic                   valid_q;

  // Row storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // A row that was never written since reset reads as cleared.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      valid_q <= row_valid[rd_addr];
    end
  end

  assign rd_data = valid_q ? mem_q : '0;

endmodule

`default_nettype wire

// File: design/csfr_span.sv
// ============================================================================
// Row span unit
// Works out, for one row, whether it is written and which columns are set.
// ============================================================================
`default_nettype none

module csfr_span
  import csfr_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64,
  localparam int RW = $clog2(MAX_ROWS)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   issue,
  input  wire logic [RW-1:0]          row_in,
  input  wire span_ctx_t              ctx,
  input  wire logic [6:0]             cols,
  output      row_ctl_t               ctl,
  output      logic [RW-1:0]          row_out,
  output      logic [MAX_COLUMNS-1:0] mask,
  output      logic                   busy
);

  coord_t   yc;
  coord_t   dy;
  coord_t   dy_abs;
  coord_t   rad;
  coord_t   half;
  coord_t   lo_c;
  coord_t   hi_c;
  row_ctl_t ctl_c;

  row_ctl_t               s1_ctl;
  logic [RW-1:0]          s1_row;
  coord_t                 s1_lo;
  coord_t                 s1_hi;
  logic [MAX_COLUMNS-1:0] mask_c;

  // Row distance and span bounds for the row being issued.
  always_comb begin
    yc     = coord_t'(row_in);
    dy     = yc - ctx.y_lo;
    dy_abs = dy[CW-1] ? -dy : dy;
    rad    = coord_t'(ctx.radius);
    half   = rad - dy_abs;
    lo_c   = ctx.x_lo;
    hi_c   = ctx.x_hi;
    ctl_c  = '{valid: issue, wr: 1'b0, cap: 1'b0, clr: 1'b0};
    unique case (ctx.op)
      OP_CLEAR: begin
        ctl_c.wr  = 1'b1;
        ctl_c.clr = 1'b1;
      end
      OP_FILL: begin
        ctl_c.wr = (yc >= ctx.y_lo) && (yc <= ctx.y_hi);
      end
      OP_DIAMOND: begin
        ctl_c.wr = (dy_abs <= rad);
        lo_c     = ctx.x_lo - half;
        hi_c     = ctx.x_lo + half;
      end
      OP_READ: begin
        ctl_c.cap = 1'b1;
      end
      default: begin
        ctl_c.wr = 1'b0;
      end
    endcase
  end

  // Column mask from the registered bounds, clipped to the columns in use.
  always_comb begin
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      mask_c[i] = (coord_t'(i) >= s1_lo) && (coord_t'(i) <= s1_hi) && (7'(i) < cols);
    end
  end

  // Two pipeline stages: bounds, then mask alongside the memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl.valid <= 1'b0;
      ctl.valid    <= 1'b0;
    end else begin
      s1_ctl.valid <= ctl_c.valid;
      ctl.valid    <= s1_ctl.valid;
    end
    s1_ctl.wr  <= ctl_c.wr;
    s1_ctl.cap <= ctl_c.cap;
    s1_ctl.clr <= ctl_c.clr;
    s1_row     <= row_in;
    s1_lo      <= lo_c;
    s1_hi      <= hi_c;
    ctl.wr     <= s1_ctl.wr;
    ctl.cap    <= s1_ctl.cap;
    ctl.clr    <= s1_ctl.clr;
    row_out    <= s1_row;
    mask       <= mask_c;
  end

  assign busy = s1_ctl.valid | ctl.valid;

endmodule

`default_nettype wire

// File: design/clipped_shape_fill_rasterizer.sv
// Sweep: a command sweeps MAX_ROWS rows for clear, the rows in use for point, rectangle
// and diamond, and one row for read; a command with no rows to sweep (zero rectangle,
// zero rows in use, spare action) goes straight to the drain state.
// Commands: a new command is taken only after the previous result has been offered; the
// sweep does one read-modify-write row per cycle.
// Reset: synchronous, active high; sizes return to 64 and rows read as zero via valid bits.
// ============================================================================
// Clipped shape fill rasterizer
// One-bit canvas with clear, point, rectangle, diamond and row read commands.
// ============================================================================
`default_nettype none

module clipped_shape_fill_rasterizer
  import csfr_pkg::*;
#(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input wire logic   clk,
  input wire logic   rst,
  csfr_cmd_if.sink   cmd,
  csfr_row_if.source res,
  csfr_cfg_if.sink   cfg
);

  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CNTW = $clog2(MAX_ROWS + 1);
  localparam int HW   = (CNTW > 7) ? CNTW : 7;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SWEEP = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t                 state;
  logic [CNTW-1:0]        ycnt;
  logic [CNTW-1:0]        n_iter;
  span_ctx_t              ctx;
  logic                   read_ok;
  logic [RW-1:0]          read_row;
  logic [MAX_COLUMNS-1:0] result;
  logic [6:0]             canvas_width;
  logic [6:0]             canvas_height;

  logic [6:0]             cols_used;
  logic [HW-1:0]          height_ext;
  logic [CNTW-1:0]        rows_used;
  logic [MAX_COLUMNS-1:0] col_mask;
  logic                   accept;

  span_ctx_t              ctx_next;
  logic [CNTW-1:0]        n_iter_next;
  logic                   read_ok_next;
  coord_t                 px;
  coord_t                 py;
  coord_t                 rw;
  coord_t                 rh;

  row_ctl_t               ctl;
  logic [RW-1:0]          row_y;
  logic [MAX_COLUMNS-1:0] mask;
  logic                   busy;
  logic [RW-1:0]          row_issue;
  logic [MAX_COLUMNS-1:0] rd_data;
  logic                   wr_en;
  logic [MAX_COLUMNS-1:0] wr_data;
  logic [RW-1:0]          u_span_row_rd;
  logic [RW-1:0]          s1_row_track;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CANVAS_SIZE_RESET;
      canvas_height <= CANVAS_SIZE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CANVAS_WIDTH:  canvas_width  <= cfg.data;
        REG_CANVAS_HEIGHT: canvas_height <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Size in use, limited by the store.
  always_comb begin
    cols_used  = (canvas_width > 7'(MAX_COLUMNS)) ? 7'(MAX_COLUMNS) : canvas_width;
    height_ext = HW'(canvas_height);
    rows_used  = CNTW'((height_ext > HW'(MAX_ROWS)) ? HW'(MAX_ROWS) : height_ext);
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      col_mask[i] = (7'(i) < cols_used);
    end
  end

  // Command decode into a sweep context.
  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;

  always_comb begin
    px           = coord_t'(cmd.pos_x);
    py           = coord_t'(cmd.pos_y);
    rw           = coord_t'(cmd.rect_width);
    rh           = coord_t'(cmd.rect_height);
    ctx_next     = '{op: OP_NONE, x_lo: px, x_hi: px, y_lo: py, y_hi: py,
                     radius: cmd.diamond_radius};
    n_iter_next  = '0;
    read_ok_next = !py[CW-1] && (py < coord_t'(rows_used));
    case (cmd.action)
      ACT_CLEAR: begin
        ctx_next.op = OP_CLEAR;
        n_iter_next = CNTW'(MAX_ROWS);
      end
      ACT_POINT: begin
        ctx_next.op = OP_FILL;
        n_iter_next = rows_used;
      end
      ACT_RECT: begin
        if ((cmd.rect_width != '0) && (cmd.rect_height != '0)) begin
          ctx_next.op   = OP_FILL;
          ctx_next.x_hi = px + rw - coord_t'(1);
          ctx_next.y_hi = py + rh - coord_t'(1);
          n_iter_next   = rows_used;
        end
      end
      ACT_DIAMOND: begin
        ctx_next.op = OP_DIAMOND;
        n_iter_next = rows_used;
      end
      ACT_READ: begin
        ctx_next.op = OP_READ;
        n_iter_next = CNTW'(1);
      end
      default: begin
        ctx_next.op = OP_NONE;
      end
    endcase
  end

  // Sweep sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready && (state != ST_DONE)) begin
        res.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= (n_iter_next == '0) ? ST_DRAIN : ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (ycnt == n_iter - CNTW'(1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!busy) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!res.valid || res.ready) begin
            res.valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Sweep payload: context, row counter, captured row and output data.
  always_ff @(posedge clk) begin
    if (accept) begin
      ctx      <= ctx_next;
      n_iter   <= n_iter_next;
      read_ok  <= read_ok_next;
      read_row <= cmd.pos_y[RW-1:0];
      ycnt     <= '0;
      result   <= '0;
    end else if (state == ST_SWEEP) begin
      ycnt <= ycnt + CNTW'(1);
    end
    if (ctl.valid && ctl.cap) begin
      result <= read_ok ? (rd_data & col_mask) : '0;
    end
    if ((state == ST_DONE) && (!res.valid || res.ready)) begin
      res.row_bits <= ROW_W'(result);
    end
  end

  assign row_issue = (ctx.op == OP_READ) ? read_row : ycnt[RW-1:0];

  csfr_span #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_span (
    .clk    (clk),
    .rst    (rst),
    .issue  (state == ST_SWEEP),
    .row_in (row_issue),
    .ctx    (ctx),
    .cols   (cols_used),
    .ctl    (ctl),
    .row_out(row_y),
    .mask   (mask),
    .busy   (busy)
  );

  // Write back: clear zeroes the row, shapes merge their span into it.
  assign wr_en   = ctl.valid && ctl.wr;
  assign wr_data = ctl.clr ? '0 : (rd_data | mask);

  csfr_canvas #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_canvas (
    .clk    (clk),
    .rst    (rst),
    .rd_addr(u_span_row_rd),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(row_y),
    .wr_data(wr_data)
  );

  // The memory is read one stage ahead of the write, at the stage one row.
  always_ff @(posedge clk) begin
    s1_row_track <= row_issue;
  end

  assign u_span_row_rd = s1_row_track;

endmodule

`default_nettype wire

// File: design/csfr_checker.sv
// ============================================================================
// Clipped shape fill rasterizer port checker
// Watches the command and result channels of the top level over time.
// ============================================================================
`default_nettype none
`include "clipped_shape_fill_rasterizer_macros.svh"

module csfr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cmd_valid,
  input wire logic        cmd_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [63:0] row_bits
);

  // A pending result stays offered and unchanged until it is taken.
  `CSFR_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid, "result dropped")
  `CSFR_ASSERT(a_res_stable, clk, rst, res_valid && !res_ready |=> $stable(row_bits), "result changed while stalled")

  // Only one command is in flight: acceptance closes the command channel.
  `CSFR_ASSERT(a_one_cmd, clk, rst, cmd_valid && cmd_ready |=> !cmd_ready, "second command taken during work")

  // A new result appears only at the end of a command's work.
  `CSFR_ASSERT(a_res_after_work, clk, rst, $rose(res_valid) |-> $past(!cmd_ready), "result without work")

  // After reset the block is ready and holds no result.
  `CSFR_ASSERT_ALWAYS(a_reset_state, clk, rst |=> cmd_ready && !res_valid, "bad state after reset")

endmodule

bind clipped_shape_fill_rasterizer csfr_checker u_csfr_checker (
  .clk      (clk),
  .rst      (rst),
  .cmd_valid(cmd.valid),
  .cmd_ready(cmd.ready),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .row_bits (res.row_bits)
);

`default_nettype wire
